FILE: rtl/avr_pkg.sv
// avr_pkg: widths, command codes and the degree sine table for axis_vector_rotate
// no dependencies; imported by every module of the block
`default_nettype none

package avr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TRIG_BITS = 16;
  localparam int TAB_BITS  = 24;
  localparam int VEC_W     = 32;
  localparam int CMD_W     = 3;
  localparam int ANG_W     = 9;
  localparam int MAG_W     = 32;
  localparam int SH_W      = 5;
  localparam int RAD_W     = 2 * MAG_W;
  localparam int SQ_REM_W  = RAD_W + 2;
  localparam int ROOT_W    = MAG_W;
  localparam int NUM_W     = MAG_W + FRAC_BITS + 1;
  localparam int DIV_REM_W = NUM_W + 1;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int N_W       = FRAC_BITS + 2;
  localparam int TRIG_W    = TRIG_BITS + 2;
  localparam int PROD_W    = N_W + TRIG_W;
  localparam int ACC_W     = PROD_W + 1;
  localparam int ROT_STAGES = 2;

  localparam logic [ANG_W-1:0] STEP_RESET = ANG_W'(10);
  localparam logic [ANG_W-1:0] FULL_TURN  = ANG_W'(360);
  localparam logic [ANG_W-1:0] HALF_TURN  = ANG_W'(180);
  localparam logic [ANG_W-1:0] QTR_TURN   = ANG_W'(90);
  localparam logic [ANG_W-1:0] TQ_TURN    = ANG_W'(270);
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam int TAB_N = 91;

  // command bits [2:1] name the axis, bit 0 the direction
  typedef enum logic [1:0] {
    AXIS_Z    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_X    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_e;

  typedef logic [TAB_BITS:0] qsin_tab_t [TAB_N];

  // quarter sine in q24, 8-term taylor series in q30
  function automatic qsin_tab_t gen_qsin();
    qsin_tab_t t;
    logic [63:0] x, x2, term, sum;
    for (int d = 0; d < TAB_N; d++) begin
      if (d == 0) begin
        t[d] = '0;
      end else if (d == TAB_N - 1) begin
        t[d] = (TAB_BITS + 1)'(1) << TAB_BITS;
      end else begin
        x = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (int k = 1; k <= 7; k++) begin
          term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
          if ((k % 2) == 1) sum = sum - term;
          else sum = sum + term;
        end
        t[d] = (TAB_BITS + 1)'((sum + 64'd32) >> 6);
      end
    end
    return t;
  endfunction

  localparam qsin_tab_t QSIN = gen_qsin();
  localparam logic [31:0] TRIG_HALF = 32'((64'd1 << (TAB_BITS - TRIG_BITS)) >> 1);

  // full-circle sine of a whole-degree angle 0..359, rounded to q(TRIG_BITS)
  function automatic logic signed [TRIG_W-1:0] trig_val(input logic [ANG_W-1:0] a);
    logic [ANG_W-1:0] idx;
    logic neg;
    logic [31:0] r;
    neg = 1'b0;
    if (a <= QTR_TURN) begin
      idx = a;
    end else if (a <= HALF_TURN) begin
      idx = HALF_TURN - a;
    end else if (a <= TQ_TURN) begin
      idx = a - HALF_TURN;
      neg = 1'b1;
    end else begin
      idx = FULL_TURN - a;
      neg = 1'b1;
    end
    r = (32'(QSIN[7'(idx)]) + TRIG_HALF) >> (TAB_BITS - TRIG_BITS);
    return neg ? -TRIG_W'(r) : TRIG_W'(r);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/avr_isqrt.sv
// avr_isqrt: pipelined floor square root, one result bit per register stage
// depends on avr_pkg
`default_nettype none

module avr_isqrt import avr_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic [ROOT_W-1:0] root_o
);

  logic [SQ_REM_W-1:0] rem_q  [ROOT_W];
  logic [ROOT_W-1:0]   root_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic [SQ_REM_W-1:0] rem_in, trial;
    logic [ROOT_W-1:0]   root_in;

    if (k == 0) begin : g_first
      assign rem_in  = SQ_REM_W'(rad_i);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // (r + 2^b)^2 - r^2
    assign trial = (SQ_REM_W'(root_in) << (B + 1)) + (SQ_REM_W'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          rem_q[k]  <= rem_in - trial;
          root_q[k] <= root_in | (ROOT_W'(1) << B);
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule

`default_nettype wire

FILE: rtl/avr_div.sv
// avr_div: pipelined restoring divider, one quotient bit per register stage
// depends on avr_pkg
`default_nettype none

module avr_div import avr_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [ROOT_W-1:0] den_i,
  output logic [QUO_W-1:0]  quo_o
);

  logic [DIV_REM_W-1:0] rem_q [QUO_W];
  logic [ROOT_W-1:0]    den_q [QUO_W];
  logic [QUO_W-1:0]     quo_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int B = QUO_W - 1 - k;
    logic [DIV_REM_W-1:0] rem_in, dsh;
    logic [ROOT_W-1:0]    den_in;
    logic [QUO_W-1:0]     quo_in;

    if (k == 0) begin : g_first
      assign rem_in = DIV_REM_W'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign dsh = DIV_REM_W'(den_in) << B;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k] <= den_in;
        if (rem_in >= dsh) begin
          rem_q[k] <= rem_in - dsh;
          quo_q[k] <= quo_in | (QUO_W'(1) << B);
        end else begin
          rem_q[k] <= rem_in;
          quo_q[k] <= quo_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

`default_nettype wire

FILE: rtl/avr_rotate.sv
// avr_rotate: two-stage planar rotation of a component pair, products then sums
// depends on avr_pkg
`default_nettype none

module avr_rotate import avr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [N_W-1:0]    a_i,
  input  logic signed [N_W-1:0]    b_i,
  input  logic signed [N_W-1:0]    k_i,
  input  logic signed [TRIG_W-1:0] cos_i,
  input  logic signed [TRIG_W-1:0] sin_i,
  output logic signed [ACC_W-1:0]  a_o,
  output logic signed [ACC_W-1:0]  b_o,
  output logic signed [ACC_W-1:0]  k_o
);

  logic signed [PROD_W-1:0] ac_q, bs_q, as_q, bc_q;
  logic signed [N_W-1:0]    k_q;
  logic signed [ACC_W-1:0]  a_q, b_q, kk_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ac_q <= a_i * cos_i;
      bs_q <= b_i * sin_i;
      as_q <= a_i * sin_i;
      bc_q <= b_i * cos_i;
      k_q  <= k_i;
    end
  end

  // a' = a cos - b sin, b' = a sin + b cos
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q  <= ACC_W'(ac_q) - ACC_W'(bs_q);
      b_q  <= ACC_W'(as_q) + ACC_W'(bc_q);
      kk_q <= ACC_W'(k_q) <<< TRIG_BITS;
    end
  end

  assign a_o = a_q;
  assign b_o = b_q;
  assign k_o = kk_q;

endmodule

`default_nettype wire

FILE: rtl/axis_vector_rotate.sv
// axis_vector_rotate: throughput one vector per cycle while the output is not stalled,
// set by the fully pipelined square root
// (32 stages) and the three dividers (17 stages each)
// the whole pipeline advances together whenever the output register is empty or taken
// reset (async, active low) clears all valid bits and sets step_degrees to 10
// top level; depends on avr_pkg, avr_isqrt, avr_div, avr_rotate
`default_nettype none

module axis_vector_rotate import avr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration: step_degrees
  input  logic                   cfg_wr_en_i,
  input  logic [ANG_W-1:0]       cfg_wr_data_i,
  // input stream
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [3*VEC_W-1:0]     s_axis_tdata_i,  // vec_x, vec_y, vec_z
  input  logic [CMD_W-1:0]       s_axis_tuser_i,  // command
  // output stream
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [3*VEC_W-1:0]     m_axis_tdata_o,  // out_x, out_y, out_z
  output logic [0:0]             m_axis_tuser_o   // zero_length
);

  localparam int LINE_N  = ROOT_W + QUO_W + ROT_STAGES;
  localparam int ISQ_TAP = ROOT_W - 1;
  localparam int DIV_TAP = ROOT_W + QUO_W - 1;
  localparam logic [63:0] RND_HALF = 64'((64'd1 << TRIG_BITS) >> 1);

  // everything an item carries alongside the arithmetic
  typedef struct packed {
    axis_e                     axis;
    logic                      zero;
    logic [2:0]                neg;
    logic signed [TRIG_W-1:0]  sin_v;
    logic signed [TRIG_W-1:0]  cos_v;
    logic [2:0][VEC_W-1:0]     vec;
    logic [2:0][MAG_W-1:0]     mag;
  } side_t;

  logic en;

  // step register
  logic [ANG_W-1:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RESET;
    end else if (cfg_wr_en_i) begin
      step_q <= cfg_wr_data_i;
    end
  end

  // stage 0: input register
  logic                  v0_q;
  logic [CMD_W-1:0]      cmd0_q;
  logic [2:0][VEC_W-1:0] vec0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd0_q <= s_axis_tuser_i;
      vec0_q <= s_axis_tdata_i;
    end
  end

  // stage 1: magnitudes, signs, angle and trig lookup
  logic             v1_q;
  side_t            side1_d, side1_q;
  logic [ANG_W-1:0] ang_base, ang;
  logic [ANG_W:0]   ang_c;

  always_comb begin
    ang_base = (step_q >= FULL_TURN) ? step_q - FULL_TURN : step_q;
    if (cmd0_q[0]) begin
      ang = (ang_base == '0) ? '0 : FULL_TURN - ang_base;
    end else begin
      ang = ang_base;
    end
    ang_c = (ANG_W + 1)'(ang) + (ANG_W + 1)'(QTR_TURN);
    if (ang_c >= (ANG_W + 1)'(FULL_TURN)) begin
      ang_c = ang_c - (ANG_W + 1)'(FULL_TURN);
    end
    side1_d       = '0;
    side1_d.axis  = axis_e'(cmd0_q[2:1]);
    side1_d.vec   = vec0_q;
    side1_d.sin_v = trig_val(ang);
    side1_d.cos_v = trig_val(ang_c[ANG_W-1:0]);
    for (int i = 0; i < 3; i++) begin
      side1_d.neg[i] = vec0_q[i][VEC_W-1];
      side1_d.mag[i] = vec0_q[i][VEC_W-1] ? MAG_W'(-vec0_q[i]) : MAG_W'(vec0_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q <= side1_d;
    end
  end

  // stage 2: largest magnitude and the shift that lifts it to bit 30
  logic             v2_q;
  side_t            side2_d, side2_q;
  logic [SH_W-1:0]  sh_d, sh2_q;
  logic [MAG_W-1:0] mx;
  logic [SH_W-1:0]  msb;

  always_comb begin
    mx = side1_q.mag[0];
    if (side1_q.mag[1] > mx) mx = side1_q.mag[1];
    if (side1_q.mag[2] > mx) mx = side1_q.mag[2];
    msb = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (mx[i]) msb = SH_W'(i);
    end
    sh_d = (msb >= SH_W'(MAG_W - 2)) ? '0 : SH_W'(MAG_W - 2) - msb;
    side2_d      = side1_q;
    side2_d.zero = (mx == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side2_q <= side2_d;
      sh2_q   <= sh_d;
    end
  end

  // stage 3: shift all magnitudes together
  logic  v3_q;
  side_t side3_d, side3_q;

  always_comb begin
    side3_d = side2_q;
    for (int i = 0; i < 3; i++) begin
      side3_d.mag[i] = side2_q.mag[i] << sh2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side3_q <= side3_d;
    end
  end

  // stage 4: squares
  logic             v4_q;
  side_t            side4_q;
  logic [RAD_W-1:0] sq4_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side4_q <= side3_q;
      for (int i = 0; i < 3; i++) begin
        sq4_q[i] <= RAD_W'(side3_q.mag[i]) * RAD_W'(side3_q.mag[i]);
      end
    end
  end

  // stage 5: sum of squares (at most 3 * 2^62, no overflow)
  logic             v5_q;
  side_t            side5_q;
  logic [RAD_W-1:0] sum5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side5_q <= side4_q;
      sum5_q  <= sq4_q[0] + sq4_q[1] + sq4_q[2];
    end
  end

  // side line: runs alongside square root, dividers and rotation
  logic  line_v_q [LINE_N];
  side_t line_q   [LINE_N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LINE_N; k++) line_v_q[k] <= 1'b0;
    end else if (en) begin
      line_v_q[0] <= v5_q;
      for (int k = 1; k < LINE_N; k++) line_v_q[k] <= line_v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      line_q[0] <= side5_q;
      for (int k = 1; k < LINE_N; k++) line_q[k] <= line_q[k-1];
    end
  end

  // vector length
  logic [ROOT_W-1:0] len;

  avr_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sum5_q),
    .root_o (len)
  );

  // normalized magnitudes: ((mag << frac) + len/2) / len
  logic [QUO_W-1:0] quo [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    logic [NUM_W-1:0] num;
    assign num = (NUM_W'(line_q[ISQ_TAP].mag[i]) << FRAC_BITS) + NUM_W'(len >> 1);

    avr_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num),
      .den_i (len),
      .quo_o (quo[i])
    );
  end

  // signed normalized components and pair selection by axis
  logic signed [N_W-1:0] n [3];
  logic signed [N_W-1:0] ra, rb, rk;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n[i] = line_q[DIV_TAP].neg[i] ? -N_W'(quo[i]) : N_W'(quo[i]);
    end
    case (line_q[DIV_TAP].axis)
      AXIS_Z: begin
        ra = n[0]; rb = n[1]; rk = n[2];
      end
      AXIS_Y: begin
        ra = n[2]; rb = n[0]; rk = n[1];
      end
      AXIS_X: begin
        ra = n[1]; rb = n[2]; rk = n[0];
      end
      default: begin
        ra = n[0]; rb = n[1]; rk = n[2];
      end
    endcase
  end

  logic signed [ACC_W-1:0] acc_a, acc_b, acc_k;

  avr_rotate u_rotate (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (ra),
    .b_i   (rb),
    .k_i   (rk),
    .cos_i (line_q[DIV_TAP].cos_v),
    .sin_i (line_q[DIV_TAP].sin_v),
    .a_o   (acc_a),
    .b_o   (acc_b),
    .k_o   (acc_k)
  );

  // round half away from zero to q(FRAC_BITS), saturate to 32 bits
  function automatic logic [VEC_W-1:0] rescale(input logic signed [ACC_W-1:0] s);
    logic [ACC_W-1:0] mag;
    logic [63:0]      r;
    mag = s[ACC_W-1] ? ACC_W'(-s) : ACC_W'(s);
    r = (64'(mag) + RND_HALF) >> TRIG_BITS;
    if (s[ACC_W-1]) begin
      return (r > 64'h8000_0000) ? 32'h8000_0000 : VEC_W'(64'd0 - r);
    end else begin
      return (r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : VEC_W'(r);
    end
  endfunction

  // output register
  side_t                 last;
  logic [2:0][VEC_W-1:0] res;
  logic [VEC_W-1:0]      oa, ob, ok;
  logic                  out_v_q;
  logic [3*VEC_W-1:0]    out_data_q;
  logic                  out_zero_q;

  assign last = line_q[LINE_N-1];
  assign oa   = rescale(acc_a);
  assign ob   = rescale(acc_b);
  assign ok   = rescale(acc_k);

  always_comb begin
    case (last.axis)
      AXIS_Z: begin
        res[0] = oa; res[1] = ob; res[2] = ok;
      end
      AXIS_Y: begin
        res[2] = oa; res[0] = ob; res[1] = ok;
      end
      AXIS_X: begin
        res[1] = oa; res[2] = ob; res[0] = ok;
      end
      default: begin
        res = last.vec;  // no rotation: pass through untouched
      end
    endcase
    if (last.axis != AXIS_NONE && last.zero) begin
      res = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= line_v_q[LINE_N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= res;
      out_zero_q <= (last.axis != AXIS_NONE) && last.zero;
    end
  end

  // pipeline advances when the output register is free or being taken
  assign en              = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_zero_q;

`ifndef SYNTH
  // a zero-length result carries zero components
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o == '0)
    else $error("zero_length result with nonzero components");

  // input side only stalls while a result waits untaken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready does not follow the output register");

  // a stall holds v5_q and the last side-line valid bit steady
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(line_v_q[LINE_N-1]) && $stable(v5_q))
    else $error("pipeline moved during a stall");
`endif

endmodule

`default_nettype wire
